>>> design/u2cp_pkg.sv
// ----------------------------------------------------------------------------
// u2cp_pkg
// Shared types and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package u2cp_pkg;

    localparam int CP_W        = 21;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] MASK_TOP2   = 8'b11000000;
    localparam logic [7:0] MASK_TOP3   = 8'b11100000;
    localparam logic [7:0] MASK_TOP4   = 8'b11110000;
    localparam logic [7:0] MASK_TOP5   = 8'b11111000;
    localparam logic [7:0] CONT_TAG    = 8'b10000000;
    localparam logic [7:0] LEAD2_TAG   = 8'b11000000;
    localparam logic [7:0] LEAD3_TAG   = 8'b11100000;
    localparam logic [7:0] LEAD4_TAG   = 8'b11110000;
    localparam logic [7:0] CONT_BITS   = 8'b00111111;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            replaced;
        logic            text_end;
    } result_t;

    // One queue entry holds every result that a single input byte causes.
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

endpackage

>>> design/utf8_to_code_point_decoder_top.sv
// A result passes the entry queue and the back end's entry register before
// it is offered. One byte per cycle while the queue has room; a byte with
// two results holds the output for two beats, and the queue absorbs that.
// The queue depth and the output handshake set how long the input may run
// ahead of a stalled output. Reset clears the open sequence and the queue.
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder_top
// UTF-8 byte stream to code point decoder with a classifying front, an entry
// queue and a result serializing back end.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder_top
    import u2cp_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_in_byte,
    input  logic            s_in_last,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic            m_replaced,
    output logic            m_text_end
);

    logic   q_full, q_push, q_pop, q_not_empty;
    entry_t q_entry, q_head;

    u2cp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .s_in_last (s_in_last),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    u2cp_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    u2cp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_code_point (m_code_point),
        .m_replaced   (m_replaced),
        .m_text_end   (m_text_end)
    );

endmodule

>>> design/u2cp_front.sv
// ----------------------------------------------------------------------------
// u2cp_front
// Accepts input bytes, tracks the open sequence and classifies each byte
// into zero, one or two results that are pushed into the queue.
// ----------------------------------------------------------------------------
module u2cp_front
    import u2cp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    input  logic       s_in_last,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_entry
);

    logic [1:0]      pending_reg, pending_next;
    logic [CP_W-1:0] partial_reg, partial_next;

    logic            accept;
    logic            is_cont;
    logic [1:0]      pend_dec;
    logic [CP_W-1:0] acc;
    logic            fresh_res;
    result_t         fresh_r;
    result_t         broken_r;
    logic [1:0]      fresh_pend;
    logic [CP_W-1:0] fresh_part;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign is_cont = (s_in_byte & MASK_TOP2) == CONT_TAG;
    assign pend_dec = pending_reg - 2'd1;
    assign acc = {partial_reg[CP_W-7:0], s_in_byte[5:0]};

    assign broken_r = '{code_point: REPLACEMENT, replaced: 1'b1, text_end: 1'b0};

    // Decode of a byte as if nothing were pending.
    always_comb begin
        fresh_res  = 1'b0;
        fresh_r    = '{code_point: REPLACEMENT, replaced: 1'b1, text_end: s_in_last};
        fresh_pend = 2'd0;
        fresh_part = '0;
        if (s_in_byte <= ASCII_MAX) begin
            fresh_res = 1'b1;
            fresh_r   = '{code_point: CP_W'(s_in_byte), replaced: 1'b0,
                          text_end: s_in_last};
        end else if ((s_in_byte & MASK_TOP3) == LEAD2_TAG) begin
            fresh_pend = 2'd1;
            fresh_part = CP_W'(s_in_byte[4:0]);
        end else if ((s_in_byte & MASK_TOP4) == LEAD3_TAG) begin
            fresh_pend = 2'd2;
            fresh_part = CP_W'(s_in_byte[3:0]);
        end else if ((s_in_byte & MASK_TOP5) == LEAD4_TAG) begin
            fresh_pend = 2'd3;
            fresh_part = CP_W'(s_in_byte[2:0]);
        end else begin
            fresh_res = 1'b1;
        end
        // A lead byte that ends the text is cut off at once.
        if (fresh_pend != 2'd0 && s_in_last) begin
            fresh_res  = 1'b1;
            fresh_pend = 2'd0;
            fresh_part = '0;
        end
    end

    always_comb begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        q_push       = 1'b0;
        q_entry      = '{two: 1'b0, r0: fresh_r, r1: fresh_r};
        if (accept) begin
            if (pending_reg != 2'd0 && is_cont) begin
                if (pend_dec == 2'd0) begin
                    q_push       = 1'b1;
                    q_entry.r0   = '{code_point: acc, replaced: 1'b0, text_end: s_in_last};
                    pending_next = 2'd0;
                    partial_next = '0;
                end else if (s_in_last) begin
                    q_push       = 1'b1;
                    q_entry.r0   = '{code_point: REPLACEMENT, replaced: 1'b1,
                                     text_end: 1'b1};
                    pending_next = 2'd0;
                    partial_next = '0;
                end else begin
                    pending_next = pend_dec;
                    partial_next = acc;
                end
            end else if (pending_reg != 2'd0) begin
                // The broken sequence is replaced, then the byte is decoded afresh.
                q_push       = 1'b1;
                q_entry.two  = fresh_res;
                q_entry.r0   = broken_r;
                pending_next = fresh_pend;
                partial_next = fresh_part;
            end else begin
                q_push       = fresh_res;
                pending_next = fresh_pend;
                partial_next = fresh_part;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
        end else begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

endmodule

>>> design/u2cp_queue.sv
// ----------------------------------------------------------------------------
// u2cp_queue
// Small register queue of result entries between the front and the back.
// ----------------------------------------------------------------------------
module u2cp_queue
    import u2cp_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output entry_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> design/u2cp_back.sv
// ----------------------------------------------------------------------------
// u2cp_back
// Takes entries from the queue and sends their results out, one per beat.
// ----------------------------------------------------------------------------
module u2cp_back
    import u2cp_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_not_empty,
    input  entry_t          q_head,
    output logic            q_pop,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [CP_W-1:0] m_code_point,
    output logic            m_replaced,
    output logic            m_text_end
);

    entry_t  ent_reg;
    logic    have_reg, have_next;
    logic    second_reg, second_next;
    logic    last_beat;
    result_t cur;

    assign cur       = second_reg ? ent_reg.r1 : ent_reg.r0;
    assign m_valid   = have_reg;
    assign m_code_point = cur.code_point;
    assign m_replaced   = cur.replaced;
    assign m_text_end   = cur.text_end;

    assign last_beat = second_reg || !ent_reg.two;
    // The next entry loads in the cycle that the last beat of this one leaves.
    assign q_pop     = q_not_empty && (!have_reg || (m_ready && last_beat));

    always_comb begin
        have_next   = have_reg;
        second_next = second_reg;
        if (q_pop) begin
            have_next   = 1'b1;
            second_next = 1'b0;
        end else if (have_reg && m_ready) begin
            if (last_beat) begin
                have_next = 1'b0;
            end else begin
                second_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_reg   <= 1'b0;
            second_reg <= 1'b0;
        end else begin
            have_reg   <= have_next;
            second_reg <= second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            ent_reg <= q_head;
        end
    end

endmodule
